### design/bb3_pkg.sv
// bb3_pkg: shared constants, types and helpers for the 3x3 edge-clipped box blur
// used by the line memory, the shared add/subtract unit and the top level
package bb3_pkg;

  // line store geometry
  localparam int MAX_COLS   = 32;
  localparam int LINE_ROWS  = 3;
  localparam int MEM_DEPTH  = LINE_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  // field widths
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 5;
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 6;
  localparam int SLOT_W     = 2;

  // accumulator holds up to nine pixels, counter up to nine taps
  localparam int ACC_W      = 12;
  localparam int CNT_W      = 4;
  localparam int QUO_W      = PIX_W;
  localparam int DIV_I_W    = $clog2(QUO_W);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROWS_CFG_W;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);

  // register reset values and limits
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(10);
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(5);
  localparam logic [ROWS_CFG_W-1:0] ROWS_MAX   = ROWS_CFG_W'(4096);
  localparam logic [COLS_CFG_W-1:0] COLS_MAX   = COLS_CFG_W'(MAX_COLS);

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ACC_W-1:0]  acc_t;

  // shared unit operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // slot of the row above, modulo three
  function automatic slot_t slot_prev(input slot_t s);
    slot_t res;
    res = (s == SLOT_W'(0)) ? SLOT_W'(LINE_ROWS - 1) : s - SLOT_W'(1);
    return res;
  endfunction

  // slot of the row below, modulo three
  function automatic slot_t slot_next(input slot_t s);
    slot_t res;
    res = (s == SLOT_W'(LINE_ROWS - 1)) ? SLOT_W'(0) : s + SLOT_W'(1);
    return res;
  endfunction

  // line store address of a row slot and column
  function automatic addr_t slot_addr(input slot_t s, input col_t c);
    addr_t res;
    res = ADDR_W'(s) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    return res;
  endfunction

endpackage

### design/box_blur_3x3_edge_clipped_unit.sv
// box_blur_3x3_edge_clipped_unit: top level, sequencer around the line store
// and the shared add/subtract unit; depends on bb3_pkg, bb3_line_mem, bb3_alu
//
// Pixels enter in raster order on the in_ channel (valid/ready). Each accepted
// pixel is written to the three-row line store and may cause up to
// frame_cols + 2 filtered results on the out_ channel, each with its row,
// column and a flag on the last result of that pixel.
// Each result reads its nine neighbour taps one per cycle through the line
// store read port, adding in-frame taps with the shared adder, then divides
// the sum by the tap count with eight restoring steps on the same unit.
// A result is worked in steps: pick it, nine tap reads, drain the read,
// eight divide steps, hand it to the output register. An input pixel
// occupies the block until its last result is handed off; in_ready is
// high only while idle.
// A result waits in the output register while out_ready is low; the sequencer
// stalls at its hand-off step until that register is free.
// Reset (rst_n low, synchronous) sets 10 rows by 5 columns, positions to the
// start of the frame and empties the output register. Writing either config
// register restarts the frame; the line store needs no clearing.
module box_blur_3x3_edge_clipped_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bb3_pkg::PIX_W-1:0]          in_pixel_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bb3_pkg::PIX_W-1:0]          out_pixel_out,
  output logic [bb3_pkg::ROW_W-1:0]          out_row,
  output logic [bb3_pkg::COL_W-1:0]          out_col,
  output logic                               out_last_of_run,
  input  logic                               cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bb3_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PLAN    = 3'd1;
  localparam logic [2:0] ST_SUM     = 3'd2;
  localparam logic [2:0] ST_SUM_END = 3'd3;
  localparam logic [2:0] ST_DIV     = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [ROWS_CFG_W-1:0] frame_rows_r, frame_rows_nxt;
  logic [COLS_CFG_W-1:0] frame_cols_r, frame_cols_nxt;
  row_t  row_pos_r, row_pos_nxt;
  col_t  col_pos_r, col_pos_nxt;
  slot_t slot_pos_r, slot_pos_nxt;

  // pending results of the current pixel
  logic  pend_a_r, pend_a_nxt;
  logic  pend_b_r, pend_b_nxt;
  logic  pend_f_r, pend_f_nxt;
  row_t  cur_row_r, cur_row_nxt;
  col_t  cur_col_r, cur_col_nxt;
  slot_t cur_slot_r, cur_slot_nxt;
  col_t  flush_k_r, flush_k_nxt;

  // result being computed
  row_t  tgt_row_r, tgt_row_nxt;
  col_t  tgt_col_r, tgt_col_nxt;
  slot_t tgt_slot_r, tgt_slot_nxt;
  logic  tgt_last_r, tgt_last_nxt;
  logic [1:0] dy_r, dy_nxt;
  logic [1:0] dx_r, dx_nxt;
  logic  tap_live_r, tap_live_nxt;
  logic  tap_in_r, tap_in_nxt;
  acc_t  acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_I_W-1:0] div_i_r, div_i_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;

  // output register
  logic  out_valid_r, out_valid_nxt;
  pix_t  out_pix_r, out_pix_nxt;
  row_t  out_row_r, out_row_nxt;
  col_t  out_col_r, out_col_nxt;
  logic  out_last_r, out_last_nxt;

  // effective frame limits
  row_t  last_row;
  col_t  last_col;

  // datapath wiring
  logic    in_xfer;
  logic    out_free;
  addr_t   mem_waddr;
  addr_t   mem_raddr;
  pix_t    mem_rdata;
  alu_op_t alu_op;
  acc_t    alu_b;
  acc_t    alu_y;
  logic    alu_carry;
  logic    row_ok;
  logic    col_ok;
  slot_t   tap_slot;
  col_t    tap_col;

  // clip the configured sizes to their legal ranges
  always_comb begin
    if (frame_rows_r == '0) begin
      last_row = '0;
    end else if (frame_rows_r > ROWS_MAX) begin
      last_row = ROW_W'(ROWS_MAX - ROWS_CFG_W'(1));
    end else begin
      last_row = ROW_W'(frame_rows_r - ROWS_CFG_W'(1));
    end
    if (frame_cols_r == '0) begin
      last_col = '0;
    end else if (frame_cols_r > COLS_MAX) begin
      last_col = COL_W'(COLS_MAX - COLS_CFG_W'(1));
    end else begin
      last_col = COL_W'(frame_cols_r - COLS_CFG_W'(1));
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign mem_waddr = slot_addr(slot_pos_r, col_pos_r);

  // tap address and in-frame test for the current neighbour
  always_comb begin
    row_ok = !((dy_r == 2'd0) && (tgt_row_r == '0)) &&
             !((dy_r == 2'd2) && (tgt_row_r == last_row));
    col_ok = !((dx_r == 2'd0) && (tgt_col_r == '0)) &&
             !((dx_r == 2'd2) && (tgt_col_r == last_col));
    tap_col = tgt_col_r + COL_W'(dx_r) - COL_W'(1);
    unique case (dy_r)
      2'd0:    tap_slot = slot_prev(tgt_slot_r);
      2'd2:    tap_slot = slot_next(tgt_slot_r);
      default: tap_slot = tgt_slot_r;
    endcase
    mem_raddr = slot_addr(tap_slot, tap_col);
  end

  // shared unit operands: add a tap, or try subtracting the shifted count
  always_comb begin
    alu_op = (state_r == ST_DIV) ? ALU_SUB : ALU_ADD;
    if (state_r == ST_DIV) begin
      alu_b = ACC_W'(cnt_r) << div_i_r;
    end else begin
      alu_b = ACC_W'(mem_rdata);
    end
  end

  bb3_line_mem u_mem (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (mem_waddr),
    .wdata (in_pixel_in),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bb3_alu u_alu (
    .op    (alu_op),
    .a     (acc_r),
    .b     (alu_b),
    .y     (alu_y),
    .carry (alu_carry)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    frame_rows_nxt = frame_rows_r;
    frame_cols_nxt = frame_cols_r;
    row_pos_nxt    = row_pos_r;
    col_pos_nxt    = col_pos_r;
    slot_pos_nxt   = slot_pos_r;
    pend_a_nxt     = pend_a_r;
    pend_b_nxt     = pend_b_r;
    pend_f_nxt     = pend_f_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    cur_slot_nxt   = cur_slot_r;
    flush_k_nxt    = flush_k_r;
    tgt_row_nxt    = tgt_row_r;
    tgt_col_nxt    = tgt_col_r;
    tgt_slot_nxt   = tgt_slot_r;
    tgt_last_nxt   = tgt_last_r;
    dy_nxt         = dy_r;
    dx_nxt         = dx_r;
    tap_live_nxt   = tap_live_r;
    tap_in_nxt     = tap_in_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    div_i_nxt      = div_i_r;
    quo_nxt        = quo_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pix_nxt    = out_pix_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        // take a pixel: note which results it causes, step the position
        if (in_valid) begin
          pend_a_nxt   = (row_pos_r != '0) && (col_pos_r != '0);
          pend_b_nxt   = (row_pos_r != '0) && (col_pos_r == last_col);
          pend_f_nxt   = (row_pos_r == last_row) && (col_pos_r == last_col);
          cur_row_nxt  = row_pos_r;
          cur_col_nxt  = col_pos_r;
          cur_slot_nxt = slot_pos_r;
          flush_k_nxt  = '0;
          if (col_pos_r == last_col) begin
            col_pos_nxt = '0;
            if (row_pos_r == last_row) begin
              row_pos_nxt  = '0;
              slot_pos_nxt = '0;
            end else begin
              row_pos_nxt  = row_pos_r + ROW_W'(1);
              slot_pos_nxt = slot_next(slot_pos_r);
            end
          end else begin
            col_pos_nxt = col_pos_r + COL_W'(1);
          end
          state_nxt = ST_PLAN;
        end
      end

      ST_PLAN: begin
        // pick the next result in emission order
        dy_nxt       = '0;
        dx_nxt       = '0;
        tap_live_nxt = 1'b0;
        tap_in_nxt   = 1'b0;
        acc_nxt      = '0;
        cnt_nxt      = '0;
        state_nxt    = ST_SUM;
        priority if (pend_a_r) begin
          tgt_row_nxt  = cur_row_r - ROW_W'(1);
          tgt_col_nxt  = cur_col_r - COL_W'(1);
          tgt_slot_nxt = slot_prev(cur_slot_r);
          tgt_last_nxt = !pend_b_r && !pend_f_r;
          pend_a_nxt   = 1'b0;
        end else if (pend_b_r) begin
          tgt_row_nxt  = cur_row_r - ROW_W'(1);
          tgt_col_nxt  = last_col;
          tgt_slot_nxt = slot_prev(cur_slot_r);
          tgt_last_nxt = !pend_f_r;
          pend_b_nxt   = 1'b0;
        end else if (pend_f_r) begin
          tgt_row_nxt  = cur_row_r;
          tgt_col_nxt  = flush_k_r;
          tgt_slot_nxt = cur_slot_r;
          tgt_last_nxt = (flush_k_r == last_col);
          pend_f_nxt   = (flush_k_r != last_col);
          flush_k_nxt  = flush_k_r + COL_W'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SUM: begin
        // add the tap read last cycle, issue the next one
        if (tap_live_r && tap_in_r) begin
          acc_nxt = alu_y;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        tap_live_nxt = 1'b1;
        tap_in_nxt   = row_ok && col_ok;
        if (dx_r == 2'd2) begin
          dx_nxt = '0;
          dy_nxt = dy_r + 2'd1;
          if (dy_r == 2'd2) begin
            state_nxt = ST_SUM_END;
          end
        end else begin
          dx_nxt = dx_r + 2'd1;
        end
      end

      ST_SUM_END: begin
        // last tap arrives from the read port
        if (tap_live_r && tap_in_r) begin
          acc_nxt = alu_y;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        tap_live_nxt = 1'b0;
        div_i_nxt    = DIV_I_W'(QUO_W - 1);
        quo_nxt      = '0;
        state_nxt    = ST_DIV;
      end

      ST_DIV: begin
        // restoring division, one quotient bit per step, msb first
        if (alu_carry) begin
          acc_nxt = alu_y;
        end
        quo_nxt = {quo_r[QUO_W-2:0], alu_carry};
        if (div_i_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          div_i_nxt = div_i_r - DIV_I_W'(1);
        end
      end

      ST_EMIT: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = quo_r;
          out_row_nxt   = tgt_row_r;
          out_col_nxt   = tgt_col_r;
          out_last_nxt  = tgt_last_r;
          state_nxt     = ST_PLAN;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // configuration write restarts the frame
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_ROWS: begin
          frame_rows_nxt = cfg_wdata;
          row_pos_nxt    = '0;
          col_pos_nxt    = '0;
          slot_pos_nxt   = '0;
        end
        REG_FRAME_COLS: begin
          frame_cols_nxt = COLS_CFG_W'(cfg_wdata);
          row_pos_nxt    = '0;
          col_pos_nxt    = '0;
          slot_pos_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frame_rows_r <= ROWS_RESET;
      frame_cols_r <= COLS_RESET;
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      slot_pos_r   <= '0;
      pend_a_r     <= 1'b0;
      pend_b_r     <= 1'b0;
      pend_f_r     <= 1'b0;
      tap_live_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_rows_r <= frame_rows_nxt;
      frame_cols_r <= frame_cols_nxt;
      row_pos_r    <= row_pos_nxt;
      col_pos_r    <= col_pos_nxt;
      slot_pos_r   <= slot_pos_nxt;
      pend_a_r     <= pend_a_nxt;
      pend_b_r     <= pend_b_nxt;
      pend_f_r     <= pend_f_nxt;
      tap_live_r   <= tap_live_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    cur_slot_r <= cur_slot_nxt;
    flush_k_r  <= flush_k_nxt;
    tgt_row_r  <= tgt_row_nxt;
    tgt_col_r  <= tgt_col_nxt;
    tgt_slot_r <= tgt_slot_nxt;
    tgt_last_r <= tgt_last_nxt;
    dy_r       <= dy_nxt;
    dx_r       <= dx_nxt;
    tap_in_r   <= tap_in_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    div_i_r    <= div_i_nxt;
    quo_r      <= quo_nxt;
    out_pix_r  <= out_pix_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_last_of_run = out_last_r;

endmodule

### design/bb3_line_mem.sv
// bb3_line_mem: three-row pixel line store, one write and one registered read port
// depends on bb3_pkg
module bb3_line_mem (
  input  logic          clk,
  input  logic          we,
  input  bb3_pkg::addr_t waddr,
  input  bb3_pkg::pix_t  wdata,
  input  bb3_pkg::addr_t raddr,
  output bb3_pkg::pix_t  rdata
);
  import bb3_pkg::*;

  pix_t mem_r [MEM_DEPTH];
  pix_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/bb3_alu.sv
// bb3_alu: shared add/subtract unit for tap accumulation and restoring division
// depends on bb3_pkg
module bb3_alu (
  input  bb3_pkg::alu_op_t op,
  input  bb3_pkg::acc_t    a,
  input  bb3_pkg::acc_t    b,
  output bb3_pkg::acc_t    y,
  output logic             carry
);
  import bb3_pkg::*;

  logic [ACC_W:0] full;
  acc_t           b_eff;

  // subtract as a plus inverted b plus one; carry set means no borrow
  always_comb begin
    b_eff = (op == ALU_SUB) ? ~b : b;
    full  = {1'b0, a} + {1'b0, b_eff} + (ACC_W + 1)'(op == ALU_SUB);
  end

  assign y     = full[ACC_W-1:0];
  assign carry = full[ACC_W];

endmodule

### design/bb3_checker.sv
// bb3_checker: port-level checks for the box blur top level, bound to it below
// depends on bb3_pkg and box_blur_3x3_edge_clipped_unit
module bb3_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bb3_pkg::PIX_W-1:0]      out_pixel_out,
  input logic [bb3_pkg::ROW_W-1:0]      out_row,
  input logic [bb3_pkg::COL_W-1:0]      out_col,
  input logic                           out_last_of_run
);
  import bb3_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_pixel_out) && $stable(out_row) &&
      $stable(out_col) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // an accepted pixel leaves the block busy in the next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // more results of the same pixel follow, so the block stays busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> !in_ready)
    else $error("ready before the last result of a pixel");

endmodule

bind box_blur_3x3_edge_clipped_unit bb3_checker u_bb3_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_out   (out_pixel_out),
  .out_row         (out_row),
  .out_col         (out_col),
  .out_last_of_run (out_last_of_run)
);
